[hdl/bgd_pkg.sv]
// ----------------------------------------------------------------------------
// bgd_pkg
// Types and codes shared by the button gesture detector modules.
// ----------------------------------------------------------------------------
package bgd_pkg;

   localparam int MASK_BITS      = 5;
   localparam int BUTTON_BITS    = 3;
   localparam int NOW_BITS       = 32;
   localparam int LONG_MS_BITS   = 16;
   localparam logic [LONG_MS_BITS-1:0] LONG_MS_RESET = 16'd500;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [1:0] {
      KIND_EVENT = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_HALT  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      EV_DOWN  = 2'd0,
      EV_UP    = 2'd1,
      EV_CLICK = 2'd2,
      EV_LONG  = 2'd3
   } event_type;

   typedef struct packed {
      logic                   op;
      logic [MASK_BITS-1:0]   buttons_mask;
      logic                   escape;
      logic [NOW_BITS-1:0]    now_ms;
      logic [BUTTON_BITS-1:0] button_index;
   } req_payload_type;

   typedef struct packed {
      kind_type               kind;
      logic [BUTTON_BITS-1:0] button;
      event_type              event_res;
      logic                   was_pressed;
      logic [MASK_BITS-1:0]   pressed_mask;
      logic                   last;
   } rsp_payload_type;

   typedef struct packed {
      logic down;
      logic up;
      logic long_click;
   } lane_evt_type;

   typedef struct packed {
      kind_type               kind;
      logic [BUTTON_BITS-1:0] button;
      logic                   was_pressed;
      logic [MASK_BITS-1:0]   pressed_mask;
   } job_load_type;

endpackage

[hdl/bgd_lane.sv]
// ----------------------------------------------------------------------------
// bgd_lane
// One button: pressed state, sticky flag, press time and edge classification.
// ----------------------------------------------------------------------------
module bgd_lane #(
   parameter int TIME_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              sample_fire,
   input  logic                              level,
   input  logic [bgd_pkg::NOW_BITS-1:0]      now_ms,
   input  logic [bgd_pkg::LONG_MS_BITS-1:0]  long_ms,
   input  logic                              query_clear,
   output logic                              pressed_next,
   output logic                              sticky,
   output bgd_pkg::lane_evt_type             evt
);
   import bgd_pkg::*;

   logic                 pressed_ff, pressed_in;
   logic                 sticky_ff, sticky_in;
   logic [TIME_BITS-1:0] press_time_ff, press_time_in;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] held;
   logic                 change;

   always_comb begin
      now_t  = TIME_BITS'(now_ms);
      held   = now_t - press_time_ff;
      change = sample_fire && (level != pressed_ff);

      evt.down       = change && level;
      evt.up         = change && !level;
      evt.long_click = held > TIME_BITS'(long_ms);

      pressed_in    = change ? level : pressed_ff;
      press_time_in = evt.down ? now_t : press_time_ff;
      if (query_clear) begin
         sticky_in = 1'b0;
      end else if (evt.down) begin
         sticky_in = 1'b1;
      end else begin
         sticky_in = sticky_ff;
      end
   end

   assign pressed_next = pressed_in;
   assign sticky       = sticky_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff    <= 1'b0;
         sticky_ff     <= 1'b0;
         press_time_ff <= '0;
      end else begin
         pressed_ff    <= pressed_in;
         sticky_ff     <= sticky_in;
         press_time_ff <= press_time_in;
      end
   end

endmodule

[hdl/bgd_merge.sv]
// ----------------------------------------------------------------------------
// bgd_merge
// Holds the results of one request and sends them one per cycle unless the
// response is stalled, lanes in index order, through the output register.
// ----------------------------------------------------------------------------
module bgd_merge #(
   parameter int NUM_BUTTONS = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  bgd_pkg::job_load_type                 load_info,
   input  bgd_pkg::lane_evt_type [NUM_BUTTONS-1:0] lane_evt,
   output logic                                  can_take,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output bgd_pkg::rsp_payload_type              rsp_payload
);
   import bgd_pkg::*;

   logic                     job_valid_ff, job_valid_in;
   job_load_type             job_ff, job_in;
   logic [NUM_BUTTONS-1:0]   down_ff, down_in;
   logic [NUM_BUTTONS-1:0]   up_ff, up_in;
   logic [NUM_BUTTONS-1:0]   click_ff, click_in;
   logic [NUM_BUTTONS-1:0]   long_ff, long_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_ff, rsp_in;

   logic [NUM_BUTTONS-1:0]   sel_oh;
   logic [BUTTON_BITS-1:0]   sel_button;
   logic                     pick_down, pick_up;
   logic [NUM_BUTTONS-1:0]   down_rem, up_rem, click_rem;
   logic                     last;
   logic                     adv;
   event_type                sel_event;

   always_comb begin
      sel_oh     = '0;
      sel_button = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (down_ff[i] || up_ff[i] || click_ff[i]) begin
            sel_oh    = '0;
            sel_oh[i] = 1'b1;
            sel_button = BUTTON_BITS'(i);
         end
      end
      pick_down = |(down_ff & sel_oh);
      pick_up   = !pick_down && |(up_ff & sel_oh);
      down_rem  = down_ff & ~(pick_down ? sel_oh : '0);
      up_rem    = up_ff & ~(pick_up ? sel_oh : '0);
      click_rem = click_ff & ~((!pick_down && !pick_up) ? sel_oh : '0);
      if (pick_down) begin
         sel_event = EV_DOWN;
      end else if (pick_up) begin
         sel_event = EV_UP;
      end else if (|(long_ff & sel_oh)) begin
         sel_event = EV_LONG;
      end else begin
         sel_event = EV_CLICK;
      end
      last     = (job_ff.kind != KIND_EVENT) || !(|(down_rem | up_rem | click_rem));
      adv      = job_valid_ff && (!rsp_valid_ff || rsp_ready);
      can_take = !job_valid_ff || (adv && last);
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      down_in      = down_ff;
      up_in        = up_ff;
      click_in     = click_ff;
      long_in      = long_ff;
      if (load) begin
         job_valid_in = 1'b1;
         job_in       = load_info;
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            down_in[i]  = lane_evt[i].down;
            up_in[i]    = lane_evt[i].up;
            click_in[i] = lane_evt[i].up;
            long_in[i]  = lane_evt[i].long_click;
         end
      end else if (adv && last) begin
         job_valid_in = 1'b0;
         down_in      = '0;
         up_in        = '0;
         click_in     = '0;
      end else if (adv) begin
         down_in  = down_rem;
         up_in    = up_rem;
         click_in = click_rem;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (adv) begin
         rsp_valid_in        = 1'b1;
         rsp_in.kind         = job_ff.kind;
         rsp_in.pressed_mask = job_ff.pressed_mask;
         rsp_in.last         = last;
         if (job_ff.kind == KIND_EVENT) begin
            rsp_in.button      = sel_button;
            rsp_in.event_res   = sel_event;
            rsp_in.was_pressed = 1'b0;
         end else begin
            rsp_in.button      = job_ff.button;
            rsp_in.event_res   = EV_DOWN;
            rsp_in.was_pressed = job_ff.was_pressed;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         down_ff      <= '0;
         up_ff        <= '0;
         click_ff     <= '0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         down_ff      <= down_in;
         up_ff        <= up_in;
         click_ff     <= click_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      long_ff <= long_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_take)
      else $error("New request loaded while results are still pending.");

   a_event_job_has_work: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && job_ff.kind == KIND_EVENT) |-> (|(down_ff | up_ff | click_ff)))
      else $error("Event job is valid with nothing left to send.");

   a_single_result_kinds: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && job_ff.kind != KIND_EVENT) |-> !(|(down_ff | up_ff | click_ff)))
      else $error("Query or halt job carries lane events.");

   a_not_last_is_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last) |-> rsp_ff.kind == KIND_EVENT)
      else $error("Only button events can be followed by more results.");

   a_idle_clears_pending: assert property (@(posedge clock) disable iff (reset)
      !job_valid_ff |-> !(|(down_ff | up_ff | click_ff)))
      else $error("Pending lane results without a valid job.");
`endif

endmodule

[hdl/button_gesture_detector.sv]
// ----------------------------------------------------------------------------
// button_gesture_detector
// Turns polled button samples into down, up, click and long-click events,
// answers sticky was-pressed queries and halts on escape.
//
//   channel  | ports                               | direction
//   ---------+-------------------------------------+----------
//   request  | req_valid, req_ready, req_payload   | in
//   response | rsp_valid, rsp_ready, rsp_payload   | out
//   csr      | csr_we, csr_wdata                   | in
//
// A request that gives results sends them from the result queue one result per
// cycle while the response is not stalled; a sample with no results loads nothing.
// The next request is taken in the cycle the last result enters the output
// register, while that result may still wait there for the response side.
// Reset clears all button state, the halt flag and sets the threshold to 500 ms.
// A stalled response holds the queue; requests wait until it can be loaded.
// ----------------------------------------------------------------------------
module button_gesture_detector #(
   parameter int NUM_BUTTONS = 5,
   parameter int TIME_BITS   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bgd_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bgd_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_we,
   input  logic [bgd_pkg::LONG_MS_BITS-1:0]  csr_wdata
);
   import bgd_pkg::*;

   logic                    halted_ff, halted_in;
   logic [MASK_BITS-1:0]    prev_ff, prev_in;
   logic [LONG_MS_BITS-1:0] long_ms_ff;

   logic                    accept;
   logic                    query_fire;
   logic                    halt_fire;
   logic                    sample_fire;
   logic                    can_take;
   logic                    load;
   logic                    was_pressed;
   logic [MASK_BITS-1:0]    mask_next;

   logic [NUM_BUTTONS-1:0]  level;
   logic [NUM_BUTTONS-1:0]  query_clear;
   logic [NUM_BUTTONS-1:0]  pressed_next;
   logic [NUM_BUTTONS-1:0]  sticky;
   lane_evt_type [NUM_BUTTONS-1:0] lane_evt;
   job_load_type            load_info;

   assign req_ready   = can_take;
   assign accept      = req_valid && req_ready && !halted_ff;
   assign query_fire  = accept && (req_payload.op == OP_QUERY);
   assign halt_fire   = accept && (req_payload.op == OP_SAMPLE) && req_payload.escape;
   assign sample_fire = accept && (req_payload.op == OP_SAMPLE) && !req_payload.escape
                        && (req_payload.buttons_mask != prev_ff);

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      if (i < MASK_BITS) begin : g_level
         assign level[i] = req_payload.buttons_mask[i];
      end else begin : g_none
         assign level[i] = 1'b0;
      end
      assign query_clear[i] = query_fire && ({29'b0, req_payload.button_index} == 32'(i));

      bgd_lane #(
         .TIME_BITS (TIME_BITS)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .sample_fire  (sample_fire),
         .level        (level[i]),
         .now_ms       (req_payload.now_ms),
         .long_ms      (long_ms_ff),
         .query_clear  (query_clear[i]),
         .pressed_next (pressed_next[i]),
         .sticky       (sticky[i]),
         .evt          (lane_evt[i])
      );
   end

   for (genvar j = 0; j < MASK_BITS; j++) begin : g_mask
      if (j < NUM_BUTTONS) begin : g_on
         assign mask_next[j] = pressed_next[j];
      end else begin : g_off
         assign mask_next[j] = 1'b0;
      end
   end

   always_comb begin
      was_pressed = |(sticky & query_clear);
      load = query_fire || halt_fire;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         load = load || lane_evt[i].down || lane_evt[i].up;
      end

      load_info.pressed_mask = mask_next;
      load_info.was_pressed  = 1'b0;
      load_info.button       = '0;
      if (query_fire) begin
         load_info.kind        = KIND_QUERY;
         load_info.button      = req_payload.button_index;
         load_info.was_pressed = was_pressed;
      end else if (halt_fire) begin
         load_info.kind = KIND_HALT;
      end else begin
         load_info.kind = KIND_EVENT;
      end

      halted_in = halted_ff || halt_fire;
      prev_in   = sample_fire ? req_payload.buttons_mask : prev_ff;
   end

   bgd_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .load_info   (load_info),
      .lane_evt    (lane_evt),
      .can_take    (can_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff  <= 1'b0;
         prev_ff    <= '0;
         long_ms_ff <= LONG_MS_RESET;
      end else begin
         halted_ff <= halted_in;
         prev_ff   <= prev_in;
         if (csr_we) begin
            long_ms_ff <= csr_wdata;
         end
      end
   end

`ifndef ASSERT_OFF
   a_halt_blocks_work: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !load)
      else $error("Work started after halt.");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("Halt flag cleared without reset.");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      $onehot0({query_fire, halt_fire, sample_fire}))
      else $error("More than one kind of work for one request.");
`endif

endmodule

[tb/sv/button_gesture_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_checker
// Watches the request, response and csr ports of the button gesture detector.
// Every accepted request is turned into the down, up, click, long-click, query
// and halt responses it should cause. Each accepted response is compared field
// by field with the oldest one still pending.
// ----------------------------------------------------------------------------
module button_gesture_checker
   import bgd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  req_payload_type          req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rsp_payload_type          rsp_payload,
   input  logic                     csr_we,
   input  logic [LONG_MS_BITS-1:0]  csr_wdata,
   output int                       outstanding,
   output int                       mismatch_count
);

   logic [MASK_BITS-1:0]    is_down;
   logic [MASK_BITS-1:0]    was_down_flag;
   logic [NOW_BITS-1:0]     down_since [MASK_BITS];
   logic [MASK_BITS-1:0]    seen_mask;
   logic                    halted;
   logic [LONG_MS_BITS-1:0] long_click_limit;
   rsp_payload_type         pending_events [$];

   task automatic derive_events(input req_payload_type r);
      rsp_payload_type    fresh [$];
      rsp_payload_type    entry;
      logic [NOW_BITS-1:0] held_ms;
      if (halted)
         return;
      if (r.op == OP_QUERY) begin
         entry = '0;
         entry.kind = KIND_QUERY;
         entry.button = r.button_index;
         if (r.button_index < MASK_BITS) begin
            entry.was_pressed = was_down_flag[r.button_index];
            was_down_flag[r.button_index] = 1'b0;
         end
         fresh.push_back(entry);
      end else if (r.escape) begin
         halted = 1'b1;
         entry = '0;
         entry.kind = KIND_HALT;
         fresh.push_back(entry);
      end else if (r.buttons_mask != seen_mask) begin
         seen_mask = r.buttons_mask;
         for (int i = 0; i < MASK_BITS; i++) begin
            if (r.buttons_mask[i] != is_down[i]) begin
               is_down[i] = r.buttons_mask[i];
               entry = '0;
               entry.kind = KIND_EVENT;
               entry.button = 3'(i);
               if (is_down[i]) begin
                  was_down_flag[i] = 1'b1;
                  down_since[i] = r.now_ms;
                  entry.event_res = EV_DOWN;
                  fresh.push_back(entry);
               end else begin
                  entry.event_res = EV_UP;
                  fresh.push_back(entry);
                  held_ms = r.now_ms - down_since[i];
                  entry.event_res = (held_ms > NOW_BITS'(long_click_limit)) ? EV_LONG : EV_CLICK;
                  fresh.push_back(entry);
               end
            end
         end
      end
      foreach (fresh[k]) begin
         fresh[k].pressed_mask = is_down;
         fresh[k].last = (k == fresh.size() - 1);
         pending_events.push_back(fresh[k]);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         is_down = '0;
         was_down_flag = '0;
         foreach (down_since[i])
            down_since[i] = '0;
         seen_mask = '0;
         halted = 1'b0;
         long_click_limit = LONG_MS_RESET;
         pending_events.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               $error("response accepted while none is pending");
               mismatch_count++;
            end else begin
               want = pending_events.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_payload.kind));
               check_field("button", 32'(want.button), 32'(rsp_payload.button));
               check_field("event_res", 32'(want.event_res), 32'(rsp_payload.event_res));
               check_field("was_pressed", 32'(want.was_pressed),
                           32'(rsp_payload.was_pressed));
               check_field("pressed_mask", 32'(want.pressed_mask),
                           32'(rsp_payload.pressed_mask));
               check_field("last", 32'(want.last), 32'(rsp_payload.last));
            end
         end
         if (req_valid && req_ready)
            derive_events(req_payload);
         if (csr_we)
            long_click_limit = csr_wdata;
      end
      outstanding = pending_events.size();
   end

endmodule

[tb/sv/button_gesture_detector_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector_test
// Drives the button gesture detector with directed corner cases of hold time,
// threshold and query index, then with random sample sequences under several
// thresholds, bursty requests and a stalling response side, and ends with a
// halt. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module button_gesture_detector_test;
   import bgd_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_payload_type         req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_payload_type         rsp_payload;
   logic                    csr_we = 1'b0;
   logic [LONG_MS_BITS-1:0] csr_wdata = '0;
   int                      outstanding;
   int                      mismatch_count;
   int                      quiet_cycles = 0;
   int                      burst_left = 0;
   bit                      steady_feed = 1'b0;
   bit                      squeeze_request = 1'b0;
   logic [MASK_BITS-1:0]    cur_mask = '0;
   logic [NOW_BITS-1:0]     wall_ms = '0;

   button_gesture_detector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   button_gesture_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      int  mode;
      int  run_left;
      int  hold_left;
      bit  squeezed;
      mode = 0;
      run_left = 0;
      hold_left = 0;
      squeezed = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_request && !squeezed) begin
            squeezed = 1'b1;
            hold_left = 250;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               mode = $urandom_range(0, 2);
               run_left = $urandom_range(8, 60);
            end
            run_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_request(input req_payload_type p);
      int gap;
      req_valid <= 1'b1;
      req_payload <= p;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = steady_feed ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_sample(input logic [MASK_BITS-1:0] mask, input logic [NOW_BITS-1:0] at_ms);
      req_payload_type p;
      p = '0;
      p.op = OP_SAMPLE;
      p.buttons_mask = mask;
      p.now_ms = at_ms;
      p.button_index = 3'($urandom_range(0, 7));
      cur_mask = mask;
      send_request(p);
   endtask

   task automatic send_query(input logic [BUTTON_BITS-1:0] idx, input logic esc);
      req_payload_type p;
      p.op = OP_QUERY;
      p.buttons_mask = 5'($urandom);
      p.escape = esc;
      p.now_ms = $urandom;
      p.button_index = idx;
      send_request(p);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_long_click(input logic [LONG_MS_BITS-1:0] value);
      drain_responses();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_item(input logic [LONG_MS_BITS-1:0] limit_ms);
      int                   pick;
      logic [MASK_BITS-1:0] m;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
         send_query(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else begin
         if (pick < 5) begin
            m = 5'($urandom);
         end else begin
            m = cur_mask ^ (5'd1 << $urandom_range(0, 4));
            if ($urandom_range(0, 2) == 0)
               m = m ^ (5'd1 << $urandom_range(0, 4));
         end
         if ($urandom_range(0, 15) == 0)
            wall_ms = $urandom;
         else
            wall_ms = wall_ms + $urandom_range(0, 2 * limit_ms + 2);
         send_sample(m, wall_ms);
      end
   endtask

   initial begin : stimulus
      logic [LONG_MS_BITS-1:0] phase_limit [4];
      req_payload_type         halt_req;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_query(3'd0, 1'b0);
      send_sample(5'b00000, 32'd0);
      send_sample(5'b11111, 32'd100);
      send_sample(5'b11111, 32'd200);
      send_query(3'd3, 1'b0);
      send_query(3'd3, 1'b0);
      send_query(3'd7, 1'b0);
      send_query(3'd5, 1'b1);
      send_sample(5'b00000, 32'd600);
      send_sample(5'b00001, 32'hFFFF_FFFF);
      send_sample(5'b00000, 32'h0000_01F4);
      send_sample(5'b10010, 32'd1000);
      send_sample(5'b10000, 32'd1501);
      send_sample(5'b00000, 32'd1500);

      set_long_click(16'd0);
      send_sample(5'b00100, 32'd10);
      send_sample(5'b00000, 32'd10);
      send_sample(5'b00100, 32'd20);
      send_sample(5'b00000, 32'd21);

      set_long_click(16'hFFFF);
      send_sample(5'b01000, 32'd0);
      send_sample(5'b00000, 32'd65535);
      send_sample(5'b01000, 32'd5);
      send_sample(5'b00000, 32'd65541);

      phase_limit[0] = 16'd50;
      phase_limit[1] = 16'($urandom_range(1, 2000));
      phase_limit[2] = 16'($urandom);
      phase_limit[3] = LONG_MS_RESET;
      wall_ms = $urandom;
      for (int ph = 0; ph < 4; ph++) begin
         set_long_click(phase_limit[ph]);
         steady_feed = (ph == 1);
         squeeze_request = squeeze_request || (ph == 1);
         for (int n = 0; n < 25; n++)
            send_random_item(phase_limit[ph]);
      end
      steady_feed = 1'b0;

      halt_req = '0;
      halt_req.op = OP_SAMPLE;
      halt_req.escape = 1'b1;
      halt_req.buttons_mask = cur_mask ^ 5'b11111;
      halt_req.now_ms = $urandom;
      send_request(halt_req);
      send_sample(cur_mask ^ 5'b00001, $urandom);
      send_query(3'd0, 1'b0);

      drain_responses();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[button_gesture_detector.f]
hdl/bgd_pkg.sv
hdl/bgd_lane.sv
hdl/bgd_merge.sv
hdl/button_gesture_detector.sv
tb/sv/button_gesture_checker.sv
tb/sv/button_gesture_detector_test.sv
